>>> hw/rtl/target_reached_detector_macros.svh
// Assertion helpers for the checker file.
`ifndef TARGET_REACHED_DETECTOR_MACROS_SVH
`define TARGET_REACHED_DETECTOR_MACROS_SVH

// Property checked only while out of reset.
`define TRD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trd assertion failed");

// Property checked at every edge, reset included.
`define TRD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("trd assertion failed");

`endif

>>> hw/rtl/trd_pkg.sv
`timescale 1ns / 1ps

package trd_pkg;

    // Dwell counter width and its saturation value
    localparam int DWELL_W = 20;
    localparam logic [DWELL_W-1:0] DWELL_MAX = {DWELL_W{1'b1}};

    // Control word decoding
    localparam logic [15:0] CW_OP_MASK    = 16'h008F;
    localparam logic [15:0] CW_OP_ENABLED = 16'h000F;
    localparam int          CW_REL_BIT    = 6;

    // Field widths
    localparam int ERR_W  = 31;
    localparam int WIN_W  = 31;
    localparam int TIME_W = 16;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEGACY_MODE = 2'd0,
        CFG_POS_WINDOW  = 2'd1,
        CFG_WINDOW_TIME = 2'd2,
        CFG_NEAR_LEVEL  = 2'd3
    } t_cfg_idx;

    // Configuration as seen by the tracking logic; dwell threshold kept saturated
    typedef struct packed {
        logic               legacy_window_mode;
        logic [WIN_W-1:0]   position_window;
        logic [DWELL_W-1:0] dwell_thr;
        logic [WIN_W-1:0]   near_level;
    } t_cfg;

    // One input item
    typedef struct packed {
        logic [ERR_W-1:0]   position_error;
        logic signed [31:0] actual_position;
        logic signed [31:0] target_position;
        logic [15:0]        cmd_word;
        logic               start_edge;
        logic               alarm_active;
        logic               drive_enabled;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic in_position;
        logic near;
    } t_out_item;

endpackage

>>> hw/rtl/trd_in_if.sv
`timescale 1ns / 1ps

interface trd_in_if;
    logic              valid;
    logic              ready;
    trd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/trd_out_if.sv
`timescale 1ns / 1ps

interface trd_out_if;
    logic               valid;
    logic               ready;
    trd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/trd_cfg_regs.sv
`timescale 1ns / 1ps

module trd_cfg_regs #(
    parameter int TICKS_PER_MS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [trd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output trd_pkg::t_cfg                      o_cfg
);

    // Product width of ticks times milliseconds, never below the counter width
    localparam int PROD_RAW_W = trd_pkg::TIME_W + $clog2(TICKS_PER_MS + 1);
    localparam int PROD_W = (PROD_RAW_W > trd_pkg::DWELL_W) ? PROD_RAW_W : trd_pkg::DWELL_W;

    trd_pkg::t_cfg     r_cfg;
    trd_pkg::t_cfg     n_cfg;
    logic [PROD_W-1:0] thr_full;

    // Dwell threshold in ticks, clipped to the counter range: a clipped threshold
    // is never exceeded, same as the full one
    assign thr_full = PROD_W'(TICKS_PER_MS) * PROD_W'(i_cfg_data[trd_pkg::TIME_W-1:0]);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (trd_pkg::t_cfg_idx'(i_cfg_idx))
                trd_pkg::CFG_LEGACY_MODE: n_cfg.legacy_window_mode = i_cfg_data[0];
                trd_pkg::CFG_POS_WINDOW:  n_cfg.position_window = i_cfg_data;
                trd_pkg::CFG_WINDOW_TIME: begin
                    if (thr_full > PROD_W'(trd_pkg::DWELL_MAX)) begin
                        n_cfg.dwell_thr = trd_pkg::DWELL_MAX;
                    end else begin
                        n_cfg.dwell_thr = thr_full[trd_pkg::DWELL_W-1:0];
                    end
                end
                trd_pkg::CFG_NEAR_LEVEL:  n_cfg.near_level = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/trd_track.sv
`timescale 1ns / 1ps

module trd_track #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  trd_pkg::t_in_item  i_item,
    input  trd_pkg::t_cfg      i_cfg,
    output trd_pkg::t_out_item o_result
);

    localparam int PW = POSITION_WIDTH;
    localparam int MW = (PW > trd_pkg::WIN_W) ? PW : trd_pkg::WIN_W;

    // State
    logic                        r_reached, n_reached;
    logic [trd_pkg::DWELL_W-1:0] r_dwell, n_dwell;
    logic signed [PW-1:0]        r_prev, n_prev;
    logic signed [PW-1:0]        r_start, n_start;
    logic signed [PW-1:0]        r_travel, n_travel;
    logic                        r_armed, n_armed;

    // Position path
    logic signed [PW-1:0]        actual_w, target_w, delta;
    logic signed [PW-1:0]        travel_base, start_pos, travel_new;
    logic signed [PW-1:0]        planned, remaining, half;
    logic [PW-1:0]               rem_mag;
    logic                        armed_base, op_en, rel_move, arm_hit;

    // Window and dwell
    logic                        do_dwell, in_win, out_win;
    logic [trd_pkg::DWELL_W-1:0] dwell_inc;
    logic                        near_hit;

    // Inputs sign-extended or truncated to the position width
    assign actual_w = PW'(i_item.actual_position);
    assign target_w = PW'(i_item.target_position);

    // Travel since move start; a start edge restarts the move first
    assign delta       = actual_w - r_prev;
    assign travel_base = i_item.start_edge ? '0 : r_travel;
    assign start_pos   = i_item.start_edge ? actual_w : r_start;
    assign armed_base  = i_item.start_edge ? 1'b0 : r_armed;
    assign op_en       = (i_item.cmd_word & trd_pkg::CW_OP_MASK) == trd_pkg::CW_OP_ENABLED;
    assign travel_new  = op_en ? travel_base + delta : travel_base;

    // Planned travel and distance left, relative or absolute move
    assign rel_move  = i_item.cmd_word[trd_pkg::CW_REL_BIT];
    assign planned   = rel_move ? target_w : target_w - start_pos;
    assign remaining = rel_move ? target_w - travel_new : target_w - actual_w;
    assign half      = planned >>> 1;
    assign arm_hit   = planned[PW-1] ? (travel_new < half) : (half < travel_new);
    assign rem_mag   = remaining[PW-1] ? PW'(-remaining) : PW'(remaining);

    // Window test per mode
    always_comb begin
        if (i_cfg.legacy_window_mode) begin
            do_dwell = 1'b1;
            in_win   = i_item.position_error < i_cfg.position_window;
            out_win  = i_item.position_error > i_cfg.position_window;
        end else begin
            do_dwell = armed_base;
            in_win   = MW'(rem_mag) <= MW'(i_cfg.position_window);
            out_win  = !in_win;
        end
    end

    assign dwell_inc = (r_dwell == trd_pkg::DWELL_MAX) ? r_dwell : r_dwell + 1'b1;
    assign near_hit  = (i_item.position_error <= i_cfg.near_level) && i_item.drive_enabled;

    // Next state
    always_comb begin
        n_reached = r_reached;
        n_dwell   = r_dwell;
        n_prev    = r_prev;
        n_start   = r_start;
        n_travel  = r_travel;
        n_armed   = r_armed;

        if (!i_cfg.legacy_window_mode) begin
            n_prev   = actual_w;
            n_start  = start_pos;
            n_travel = travel_new;
            n_armed  = armed_base;
            if (!armed_base) begin
                n_reached = 1'b0;
                n_armed   = arm_hit;
            end
        end

        // Dwell: count ticks inside, flag once past the threshold
        if (do_dwell) begin
            if (r_reached) begin
                n_dwell = '0;
                if (out_win) begin
                    n_reached = 1'b0;
                end
            end else if (in_win && !i_item.alarm_active) begin
                n_dwell = dwell_inc;
                if (dwell_inc > i_cfg.dwell_thr) begin
                    n_reached = 1'b1;
                end
            end else begin
                n_dwell = '0;
            end
        end

        // Drive off clears the detector, tracking carries on
        if (!i_item.drive_enabled) begin
            n_reached = 1'b0;
            n_dwell   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached <= 1'b0;
            r_dwell   <= '0;
            r_prev    <= '0;
            r_start   <= '0;
            r_travel  <= '0;
            r_armed   <= 1'b0;
        end else if (i_step) begin
            r_reached <= n_reached;
            r_dwell   <= n_dwell;
            r_prev    <= n_prev;
            r_start   <= n_start;
            r_travel  <= n_travel;
            r_armed   <= n_armed;
        end
    end

    assign o_result.in_position = n_reached;
    assign o_result.near        = near_hit;

endmodule

>>> hw/rtl/target_reached_detector.sv
`timescale 1ns / 1ps

// Servo in-position and near detector, one item per control tick.
// Input channel i_in_ch carries one tick: following error, actual and target
// position, control word, start edge, alarm and enable flags. Output channel
// o_res carries in_position and near for that tick, one result per item.
// Both channels use valid/ready; a transfer happens when both are high.
// Pipeline: the input register takes the item at the transfer, and the result
// register takes its result when stage 1 advances, which raises o_res.valid;
// the result transfer follows once o_res.ready is high.
// Throughput: one item per cycle unless stalled; the position adders, midpoint
// compare and dwell counter all settle between the input and result registers.
// Receiver stall: the result register holds, the input register holds one more
// item, then i_in_ch.ready drops until o_res is taken.
// Reset (i_rst_n low, synchronous): both channels empty, tracking and dwell
// state cleared, all configuration registers back to 0.
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is high;
// write only while no item is in flight.
module target_reached_detector #(
    parameter int POSITION_WIDTH = 32,
    parameter int TICKS_PER_MS   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    trd_in_if.sink                         i_in_ch,
    trd_out_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    trd_pkg::t_cfg      cfg;
    trd_pkg::t_in_item  r_s1_item;
    logic               r_s1_valid;
    trd_pkg::t_out_item r_out_item;
    logic               r_out_valid;
    trd_pkg::t_out_item result;
    logic               s1_adv, in_xfer, step;

    trd_cfg_regs #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    trd_track #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_s1_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Handshake: result register free or being drained lets stage 1 move
    assign s1_adv          = !r_out_valid || o_res.ready;
    assign i_in_ch.ready   = !r_s1_valid || s1_adv;
    assign in_xfer         = i_in_ch.valid && i_in_ch.ready;
    assign step            = s1_adv && r_s1_valid;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= i_in_ch.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_item;

endmodule

>>> hw/rtl/trd_checker.sv
`timescale 1ns / 1ps
`include "target_reached_detector_macros.svh"

module trd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_in_position,
    input logic i_near
);

    // No result comes out of reset
    `TRD_ASSERT_ALWAYS(a_out_empty_after_reset, i_clk, !i_rst_n |=> !i_out_valid)

    // A stalled result holds its value
    `TRD_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_in_position) && $stable(i_near)))

    // Every input transfer is followed by a valid result on the output channel
    `TRD_ASSERT(a_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready) |-> ##2 i_out_valid)

    // An empty result register never blocks the input
    `TRD_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)

endmodule

bind target_reached_detector trd_checker u_trd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_ch.valid),
    .i_in_ready    (i_in_ch.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_in_position (o_res.data.in_position),
    .i_near        (o_res.data.near)
);
